// ===== rtl/cm3mm_pkg.sv =====
// Package for the 3x3 complex matrix multiplier.
// Holds types, sizing constants, index and rounding helpers.
// No dependencies.
package cm3mm_pkg;

    localparam int MATRIX_DIM = 3;
    localparam int WORD_BITS  = 32;
    localparam int FRAC_BITS  = WORD_BITS - 3;
    localparam int CELLS      = MATRIX_DIM * MATRIX_DIM;
    localparam int CELL_W     = $clog2(CELLS);
    localparam int DIM_W      = $clog2(MATRIX_DIM);
    localparam int PROD_W     = 2 * WORD_BITS;
    localparam int ACC_W      = PROD_W + 4;

    localparam int KIND_BIT_HL = 0;
    localparam int KIND_BIT_HR = 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN
    } t_state;

    // real-product phase within one complex MAC term
    typedef enum logic [1:0] {
        PH_RR,
        PH_II,
        PH_RI,
        PH_IR
    } t_phase;

    typedef struct packed {
        logic signed [WORD_BITS-1:0] re;
        logic signed [WORD_BITS-1:0] im;
    } t_cplx;

    function automatic logic [CELL_W-1:0] cell_idx(input logic [DIM_W-1:0] row,
                                                   input logic [DIM_W-1:0] col);
        return CELL_W'(CELL_W'(row) * CELL_W'(MATRIX_DIM) + CELL_W'(col));
    endfunction

    // round to nearest (ties up), then saturate to a word
    function automatic logic [WORD_BITS-1:0] round_sat(input logic signed [ACC_W-1:0] acc);
        logic signed [ACC_W-1:0] sum;
        logic signed [ACC_W-1:0] sh;
        logic signed [ACC_W-1:0] wmax;
        logic signed [ACC_W-1:0] wmin;
        sum  = acc + (ACC_W'(1) << (FRAC_BITS - 1));
        sh   = sum >>> FRAC_BITS;
        wmax = {{(ACC_W-WORD_BITS+1){1'b0}}, {(WORD_BITS-1){1'b1}}};
        wmin = ~wmax;
        if (sh > wmax) begin
            return wmax[WORD_BITS-1:0];
        end else if (sh < wmin) begin
            return wmin[WORD_BITS-1:0];
        end
        return sh[WORD_BITS-1:0];
    endfunction

endpackage

// ===== rtl/complex_3x3_matrix_multiply_top.sv =====
// 3x3 complex matrix multiplier with optional conjugate transposes.
// One shared 32x32 multiplier and two accumulators (real, imaginary) under a small sequencer.
// Depends on cm3mm_pkg.
//
//  channel  | handshake          | word
//  ---------+--------------------+---------------------------------------------
//  input    | start && !busy     | i_kind, i_b_real, i_b_imag, i_c_real, i_c_imag
//  result   | o_strobe (1 cycle) | o_prod_real, o_prod_imag, o_final_flag
//
// Items one to eight only load the stores.
// The ninth item starts the run: 108 real products through the single
// multiplier, one per cycle; busy stays high and drops with the last
// result. Reset (synchronous) clears the load count and the sequencer;
// store contents are undefined until loaded. No receiver stall.
module complex_3x3_matrix_multiply_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    input  logic [1:0]  i_kind,
    input  logic signed [31:0] i_b_real,
    input  logic signed [31:0] i_b_imag,
    input  logic signed [31:0] i_c_real,
    input  logic signed [31:0] i_c_imag,
    output logic        busy,
    output logic        o_strobe,
    output logic signed [31:0] o_prod_real,
    output logic signed [31:0] o_prod_imag,
    output logic        o_final_flag
);

    localparam int W  = cm3mm_pkg::WORD_BITS;
    localparam int CW = cm3mm_pkg::CELL_W;
    localparam int DW = cm3mm_pkg::DIM_W;
    localparam int AW = cm3mm_pkg::ACC_W;
    localparam int PW = cm3mm_pkg::PROD_W;
    localparam logic [DW-1:0] LAST_IDX = DW'(cm3mm_pkg::MATRIX_DIM - 1);

    cm3mm_pkg::t_cplx left_mem  [cm3mm_pkg::CELLS];
    cm3mm_pkg::t_cplx right_mem [cm3mm_pkg::CELLS];

    cm3mm_pkg::t_state r_state, n_state;
    logic [CW-1:0] r_load_count, n_load_count;
    logic [DW-1:0] r_i, n_i, r_j, n_j, r_k, n_k;
    cm3mm_pkg::t_phase r_p, n_p;
    logic r_herm_l, r_herm_r;

    logic accept;
    logic ninth;
    logic [CW-1:0] li, ri;

    // stage 1: read data
    cm3mm_pkg::t_cplx r_lrd, r_rrd;
    logic r_v1, r_first1, r_last1, r_fin1;
    cm3mm_pkg::t_phase r_p1;

    // stage 2: product
    logic signed [W-1:0] mul_a, mul_b;
    logic mul_neg;
    logic signed [PW-1:0] r_prod;
    logic r_v2, r_first2, r_last2, r_fin2, r_sub2;
    cm3mm_pkg::t_phase r_p2;

    // stage 3: accumulators
    logic signed [AW-1:0] term;
    logic signed [AW-1:0] r_acc_re, r_acc_im;
    logic r_done3, r_fin3;

    assign accept = start && !busy;
    assign ninth  = (r_load_count == CW'(cm3mm_pkg::CELLS - 1));
    assign busy   = (r_state != cm3mm_pkg::ST_IDLE);

    assign li = r_herm_l ? cm3mm_pkg::cell_idx(r_k, r_i) : cm3mm_pkg::cell_idx(r_i, r_k);
    assign ri = r_herm_r ? cm3mm_pkg::cell_idx(r_j, r_k) : cm3mm_pkg::cell_idx(r_k, r_j);

    always_ff @(posedge i_clk) begin
        if (accept) begin
            left_mem[r_load_count]  <= '{re: i_b_real, im: i_b_imag};
            right_mem[r_load_count] <= '{re: i_c_real, im: i_c_imag};
        end
        r_lrd <= left_mem[li];
        r_rrd <= right_mem[ri];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= cm3mm_pkg::ST_IDLE;
            r_load_count <= '0;
            r_i          <= '0;
            r_j          <= '0;
            r_k          <= '0;
            r_p          <= cm3mm_pkg::PH_RR;
        end else begin
            r_state      <= n_state;
            r_load_count <= n_load_count;
            r_i          <= n_i;
            r_j          <= n_j;
            r_k          <= n_k;
            r_p          <= n_p;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && ninth) begin
            r_herm_l <= i_kind[cm3mm_pkg::KIND_BIT_HL];
            r_herm_r <= i_kind[cm3mm_pkg::KIND_BIT_HR];
        end
    end

    always_comb begin
        n_state      = r_state;
        n_load_count = r_load_count;
        n_i          = r_i;
        n_j          = r_j;
        n_k          = r_k;
        n_p          = r_p;
        unique case (r_state)
            cm3mm_pkg::ST_IDLE: begin
                if (accept) begin
                    if (ninth) begin
                        n_load_count = '0;
                        n_state      = cm3mm_pkg::ST_RUN;
                        n_i          = '0;
                        n_j          = '0;
                        n_k          = '0;
                        n_p          = cm3mm_pkg::PH_RR;
                    end else begin
                        n_load_count = r_load_count + CW'(1);
                    end
                end
            end
            cm3mm_pkg::ST_RUN: begin
                unique case (r_p)
                    cm3mm_pkg::PH_RR: n_p = cm3mm_pkg::PH_II;
                    cm3mm_pkg::PH_II: n_p = cm3mm_pkg::PH_RI;
                    cm3mm_pkg::PH_RI: n_p = cm3mm_pkg::PH_IR;
                    cm3mm_pkg::PH_IR: n_p = cm3mm_pkg::PH_RR;
                    default:          n_p = cm3mm_pkg::PH_RR;
                endcase
                if (r_p == cm3mm_pkg::PH_IR) begin
                    if (r_k == LAST_IDX) begin
                        n_k = '0;
                        if (r_j == LAST_IDX) begin
                            n_j = '0;
                            if (r_i == LAST_IDX) begin
                                n_i     = '0;
                                n_state = cm3mm_pkg::ST_DRAIN;
                            end else begin
                                n_i = r_i + DW'(1);
                            end
                        end else begin
                            n_j = r_j + DW'(1);
                        end
                    end else begin
                        n_k = r_k + DW'(1);
                    end
                end
            end
            cm3mm_pkg::ST_DRAIN: begin
                if (r_done3 && r_fin3) begin
                    n_state = cm3mm_pkg::ST_IDLE;
                end
            end
            default: n_state = cm3mm_pkg::ST_IDLE;
        endcase
    end

    // pipeline tags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_done3 <= 1'b0;
        end else begin
            r_v1    <= (r_state == cm3mm_pkg::ST_RUN);
            r_v2    <= r_v1;
            r_done3 <= r_v2 && r_last2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p1     <= r_p;
        r_first1 <= (r_k == '0);
        r_last1  <= (r_k == LAST_IDX) && (r_p == cm3mm_pkg::PH_IR);
        r_fin1   <= (r_i == LAST_IDX) && (r_j == LAST_IDX);
        r_p2     <= r_p1;
        r_first2 <= r_first1;
        r_last2  <= r_last1;
        r_fin2   <= r_fin1;
        r_fin3   <= r_fin2;
    end

    // shared multiplier operand select
    always_comb begin
        unique case (r_p1)
            cm3mm_pkg::PH_RR: begin
                mul_a   = r_lrd.re;
                mul_b   = r_rrd.re;
                mul_neg = 1'b0;
            end
            cm3mm_pkg::PH_II: begin
                mul_a   = r_lrd.im;
                mul_b   = r_rrd.im;
                mul_neg = (r_herm_l == r_herm_r);
            end
            cm3mm_pkg::PH_RI: begin
                mul_a   = r_lrd.re;
                mul_b   = r_rrd.im;
                mul_neg = r_herm_r;
            end
            cm3mm_pkg::PH_IR: begin
                mul_a   = r_lrd.im;
                mul_b   = r_rrd.re;
                mul_neg = r_herm_l;
            end
            default: begin
                mul_a   = r_lrd.re;
                mul_b   = r_rrd.re;
                mul_neg = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        r_sub2 <= mul_neg;
    end

    assign term = r_sub2 ? -AW'(r_prod) : AW'(r_prod);

    always_ff @(posedge i_clk) begin
        if (r_v2) begin
            priority case (r_p2)
                cm3mm_pkg::PH_RR: r_acc_re <= r_first2 ? term : r_acc_re + term;
                cm3mm_pkg::PH_II: r_acc_re <= r_acc_re + term;
                cm3mm_pkg::PH_RI: r_acc_im <= r_first2 ? term : r_acc_im + term;
                default:          r_acc_im <= r_acc_im + term;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_strobe     <= 1'b0;
            o_final_flag <= 1'b0;
        end else begin
            o_strobe     <= r_done3;
            o_final_flag <= r_done3 && r_fin3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_done3) begin
            o_prod_real <= cm3mm_pkg::round_sat(r_acc_re);
            o_prod_imag <= cm3mm_pkg::round_sat(r_acc_im);
        end
    end

    a_pipe_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 || r_v2 || r_done3) |-> busy)
        else $error("pipeline active while idle");

    a_final_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_final_flag |-> o_strobe)
        else $error("final flag without strobe");

    a_final_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_final_flag) |-> !busy)
        else $error("busy after final word");

    a_run_on_ninth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !ninth) |=> !busy)
        else $error("run started before ninth word");

endmodule
